[rtl/core/isort_pkg.sv]
// Shared types and constants for the insertion sort engine.
package isort_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W       = 32;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    data_t data;
  } store_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_FIN,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

endpackage

[rtl/core/isort_if.sv]
// Valid/ready channel interfaces for input words and result words.
interface isort_in_if;
  import isort_pkg::*;
  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
  import isort_pkg::*;
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_res;
  logic  overflow;

  modport source (output valid, output sorted_value, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_res, input overflow,
                output ready);
endinterface

[rtl/core/isort_store.sv]
// Sorted value store: one write port, one read port with registered read data.
module isort_store (
  input  logic                clk,
  input  isort_pkg::store_wr_t wr,
  input  isort_pkg::addr_t    rd_addr,
  output isort_pkg::data_t    rd_data
);
  import isort_pkg::*;

  data_t mem [MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/insertion_sort_engine.sv]
// Insertion sort engine top level: sequencer around the sorted store.
// Words arrive one at a time on item; each is inserted into a sorted store of
// MAX_ELEMENTS entries, moving ahead of stored values only while they are strictly
// greater, so equal values keep arrival order. The word flagged last ends the run:
// the whole list leaves on result in ascending order, the final word marked by
// last_res, and the store empties. Words that find the store full are dropped and
// every result of that run shows overflow. An insertion step reads the stored value
// below the word's slot and, on the single comparator, moves it up a place if it is
// greater; the store has one read port, whose read data is registered. A result
// word is read, loaded into the output register and held on result until taken.
// item is not ready while a word is being inserted or results are being sent.
module insertion_sort_engine (
  input logic  clk,
  input logic  rst,
  isort_in_if.sink    item,
  isort_out_if.source result
);
  import isort_pkg::*;

  state_t    state, state_next;
  cnt_t      pos, pos_next;
  cnt_t      count, count_next;
  logic      dropped, dropped_next;
  addr_t     k, k_next;
  data_t     v;
  logic      v_last;
  data_t     out_value;
  logic      out_last;
  logic      out_ovf;
  logic      load_in;
  logic      load_out;
  store_wr_t wr;
  addr_t     rd_addr;
  data_t     rd_data;
  cnt_t      pos_m1;

  isort_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pos_m1 = pos - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      count   <= '0;
      dropped <= 1'b0;
      k       <= '0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      count   <= count_next;
      dropped <= dropped_next;
      k       <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      v      <= item.value;
      v_last <= item.last;
    end
    if (load_out) begin
      out_value <= rd_data;
      out_last  <= ((CNT_W'(k) + CNT_W'(1)) == count);
      out_ovf   <= dropped;
    end
  end

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    count_next   = count;
    dropped_next = dropped;
    k_next       = k;
    wr           = '0;
    rd_addr      = k;
    load_in      = 1'b0;
    load_out     = 1'b0;
    item.ready   = 1'b0;
    result.valid = 1'b0;
    case (state)
      S_IDLE: begin
        item.ready = !rst;
        if (item.valid && !rst) begin
          load_in = 1'b1;
          if (count < CNT_W'(MAX_ELEMENTS)) begin
            pos_next   = count;
            state_next = S_SEARCH;
          end else begin
            dropped_next = 1'b1;
            state_next   = S_FIN;
          end
        end
      end
      S_SEARCH: begin
        if (pos == '0) begin
          wr         = '{en: 1'b1, addr: '0, data: v};
          count_next = count + CNT_W'(1);
          state_next = S_FIN;
        end else begin
          rd_addr    = pos_m1[ADDR_W-1:0];
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_data > v) begin
          wr         = '{en: 1'b1, addr: pos[ADDR_W-1:0], data: rd_data};
          pos_next   = pos_m1;
          state_next = S_SEARCH;
        end else begin
          wr         = '{en: 1'b1, addr: pos[ADDR_W-1:0], data: v};
          count_next = count + CNT_W'(1);
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (v_last) begin
          k_next     = '0;
          state_next = S_EMIT_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        rd_addr    = k;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        load_out   = 1'b1;
        state_next = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        result.valid = 1'b1;
        if (result.ready) begin
          if (out_last) begin
            count_next   = '0;
            dropped_next = 1'b0;
            state_next   = S_IDLE;
          end else begin
            k_next     = k + ADDR_W'(1);
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign result.sorted_value = out_value;
  assign result.last_res     = out_last;
  assign result.overflow     = out_ovf;

endmodule

[rtl/core/isort_chk.sv]
// Port-level assertions for the insertion sort engine, bound to the top level.
module isort_chk (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_last,
  input logic                    out_valid,
  input logic                    out_ready,
  input isort_pkg::data_t        out_value,
  input logic                    out_last,
  input logic                    out_ovf
);
  import isort_pkg::*;

  // no input word taken while results are offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result valid");

  // a non-final word produces no result right after it is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_last) |=> !out_valid)
    else $error("result right after non-final word");

  // the run ends after the marked final result
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result after final word of run");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_value) && $stable(out_last) && $stable(out_ovf)))
    else $error("stalled result changed");

endmodule

bind insertion_sort_engine isort_chk u_isort_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_last   (item.last),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_value (result.sorted_value),
  .out_last  (result.last_res),
  .out_ovf   (result.overflow)
);

[dv/tb_insertion_sort_engine.sv]
// Self-checking testbench for the insertion sort engine: random runs, stalls, result check.
module tb_insertion_sort_engine;
  import isort_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  typedef enum int {
    RUN_MIXED,
    RUN_ASC,
    RUN_DESC,
    RUN_EQUAL
  } run_mode_t;

  typedef struct {
    data_t value;
    logic  last;
  } in_word_t;

  typedef struct {
    data_t value;
    logic  last_res;
    logic  overflow;
  } out_word_t;

  logic clk;
  logic rst;

  isort_in_if  item_if ();
  isort_out_if res_if ();

  insertion_sort_engine u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (res_if)
  );

  in_word_t  pending_words[$];
  out_word_t expected_results[$];

  data_t sorted_list[MAX_ELEMENTS];
  int    list_len;
  logic  list_dropped;

  logic in_fire;
  int   words_sent;
  int   words_in;
  int   results_seen;
  int   runs_done;
  int   ovf_runs;
  int   errors;
  int   idle_cycles;
  int   total_queued;
  logic gap_free;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Absorb one accepted word; a last word releases the sorted list.
  task automatic absorb_word(input data_t v, input logic is_last);
    int pos;
    out_word_t r;
    if (list_len < MAX_ELEMENTS) begin
      pos = list_len;
      while (pos > 0 && sorted_list[pos-1] > v) begin
        sorted_list[pos] = sorted_list[pos-1];
        pos--;
      end
      sorted_list[pos] = v;
      list_len++;
    end else begin
      list_dropped = 1'b1;
    end
    if (is_last) begin
      for (int k = 0; k < list_len; k++) begin
        r.value    = sorted_list[k];
        r.last_res = (k == list_len - 1);
        r.overflow = list_dropped;
        expected_results.insert(expected_results.size(), r);
      end
      runs_done++;
      if (list_dropped) ovf_runs++;
      list_len     = 0;
      list_dropped = 1'b0;
    end
  endtask

  function automatic data_t pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: pick_value = data_t'(32'h8000_0000);
      1: pick_value = data_t'(32'h7fff_ffff);
      2, 3: pick_value = data_t'($urandom_range(0, 8)) - data_t'(4);
      4: pick_value = ($urandom_range(0, 1) != 0) ? data_t'(0) : data_t'(-1);
      default: pick_value = data_t'($urandom);
    endcase
  endfunction

  task automatic queue_word(input data_t v, input logic l);
    in_word_t w;
    w.value = v;
    w.last  = l;
    pending_words.insert(pending_words.size(), w);
    total_queued++;
  endtask

  task automatic add_run(input int len, input run_mode_t mode);
    data_t base;
    data_t v;
    base = pick_value();
    for (int i = 0; i < len; i++) begin
      case (mode)
        RUN_ASC: v = base + data_t'(i);
        RUN_DESC: v = base - data_t'(i);
        RUN_EQUAL: v = base;
        default: v = pick_value();
      endcase
      queue_word(v, i == len - 1);
    end
  endtask

  // driver
  always @(negedge clk) begin
    in_word_t w;
    if (!rst) begin
      if (!item_if.valid || in_fire) begin
        if (pending_words.size() > 0 && (gap_free || $urandom_range(0, 99) >= 25)) begin
          w = pending_words.pop_front();
          item_if.valid <= 1'b1;
          item_if.value <= w.value;
          item_if.last  <= w.last;
          words_sent++;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
      res_if.ready <= gap_free || ($urandom_range(0, 99) >= 25);
    end
  end

  assign gap_free = (words_sent >= 200) && (words_sent < 300);

  // monitor and checker
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      in_fire     <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_fire <= item_if.valid && item_if.ready;
      if (item_if.valid && item_if.ready) begin
        words_in++;
        absorb_word(item_if.value, item_if.last);
      end
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: value=%0d last=%b ovf=%b",
                     res_if.sorted_value, res_if.last_res, res_if.overflow);
        end else begin
          exp_w = expected_results.pop_front();
          if (res_if.sorted_value !== exp_w.value || res_if.last_res !== exp_w.last_res ||
              res_if.overflow !== exp_w.overflow) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: exp value=%0d last=%b ovf=%b, got value=%0d last=%b ovf=%b",
                       exp_w.value, exp_w.last_res, exp_w.overflow,
                       res_if.sorted_value, res_if.last_res, res_if.overflow);
          end
        end
      end
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst && idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int len;
    run_mode_t mode;
    rst           = 1'b1;
    item_if.valid = 1'b0;
    item_if.value = '0;
    item_if.last  = 1'b0;
    res_if.ready  = 1'b0;
    list_len      = 0;
    list_dropped  = 1'b0;
    words_sent    = 0;
    words_in      = 0;
    results_seen  = 0;
    runs_done     = 0;
    ovf_runs      = 0;
    errors        = 0;
    total_queued  = 0;

    // directed: single word, extremes mixed, descending, duplicates
    queue_word(data_t'(32'h8000_0000), 1'b1);
    queue_word(data_t'(32'h7fff_ffff), 1'b0);
    queue_word(data_t'(32'h8000_0000), 1'b0);
    queue_word(data_t'(-1), 1'b0);
    queue_word(data_t'(0), 1'b0);
    queue_word(data_t'(1), 1'b0);
    queue_word(data_t'(32'h8000_0000), 1'b0);
    queue_word(data_t'(32'h7fff_ffff), 1'b1);
    add_run(5, RUN_DESC);
    add_run(4, RUN_EQUAL);
    queue_word(data_t'(32'h7fff_ffff), 1'b1);

    // full store, last word dropped, several words dropped
    add_run(MAX_ELEMENTS, RUN_MIXED);
    add_run(MAX_ELEMENTS + 1, RUN_MIXED);
    add_run(MAX_ELEMENTS + 6, RUN_DESC);
    while (total_queued < 470) begin
      case ($urandom_range(0, 19))
        0: len = MAX_ELEMENTS;
        1: len = MAX_ELEMENTS + 1;
        2: len = $urandom_range(MAX_ELEMENTS + 2, MAX_ELEMENTS + 8);
        default: len = $urandom_range(1, 10);
      endcase
      mode = ($urandom_range(0, 3) == 0) ? run_mode_t'($urandom_range(1, 3)) : RUN_MIXED;
      add_run(len, mode);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_words.size() > 0 || item_if.valid) @(negedge clk);
    while (expected_results.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d input words in %0d runs (%0d with overflow), %0d result words",
             words_in, runs_done, ovf_runs, results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_results.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
